// ===== rtl/uha_pkg.sv =====
// Shared types and constants for the uniform-bin histogram accumulator.
package uha_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int COUNT_BITS    = 32;
	localparam int BIN_BITS      = 8;
	localparam int PROB_BITS     = 17;
	localparam int DIV_BITS      = 16;
	localparam int STEP_BITS     = $clog2(DIV_BITS);
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam int BIU_BITS      = 9;

	localparam logic FUNC_ADD  = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_EDGE    = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BIN_WIDTH   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BINS_IN_USE = 2'd2;

	localparam logic signed [SAMPLE_BITS-1:0] LOW_EDGE_RST = 16'sd0;
	localparam logic [SAMPLE_BITS-1:0]        BIN_WIDTH_RST = 16'd256;
	localparam logic [BIU_BITS-1:0]           BINS_IN_USE_RST = 9'd256;

	localparam logic [PROB_BITS-1:0] PROB_ONE = 17'h10000;

	typedef struct packed {
		logic                          func;
		logic signed [SAMPLE_BITS-1:0] sample;
		logic [BIN_BITS-1:0]           bin_index;
	} item_t;

	typedef struct packed {
		logic                  accepted;
		logic [BIN_BITS-1:0]   bin;
		logic [COUNT_BITS-1:0] bin_count;
		logic [COUNT_BITS-1:0] total_count;
		logic [PROB_BITS-1:0]  probability;
		logic                  empty_res;
	} result_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] low_edge;
		logic [SAMPLE_BITS-1:0]        bin_width;
		logic [BIU_BITS-1:0]           bins_in_use;
	} cfg_t;

	typedef struct packed {
		logic clr_step;
		logic load;
		logic rd_issue;
		logic divb_start;
		logic div_step;
		logic clamp_rd;
		logic fetch;
		logic eval;
		logic divr_start;
		logic take_prob;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_read;
		logic below;
		logic div_last;
		logic total_zero;
		logic cnt_ge_total;
	} stat_t;

endpackage

// ===== rtl/uniform_histogram_accumulator.sv =====
// Top level of the uniform-bin histogram accumulator: configuration registers and core.
//
//   channel   direction  handshake              word
//   item      in         start & !busy          uha_pkg::item_t
//   result    out        done (one cycle)       uha_pkg::result_t
//   cfg       in         cfg_valid & cfg_ready  cfg_index, cfg_data
//
// Add: 16-step bin divide, memory read-modify-write, then 16-step probability divide;
// the probability divide is skipped when the bin holds the whole total, and a sample
// below the low edge skips both divides and the memory. Read: memory read, then the
// probability divide, skipped when the total is zero or the bin holds the whole total.
// Both divides use the one shared bit-serial divider, one quotient bit per cycle.
// Reset clears the count memory in a pass over all MAX_BINS entries with busy held high.
// Results cannot be stalled; cfg_ready is always high.
module uniform_histogram_accumulator #(
	parameter int MAX_BINS = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  uha_pkg::item_t                       item,
	output logic                                 done,
	output uha_pkg::result_t                     result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [uha_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [uha_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	uha_pkg::cfg_t  cfg_q;
	uha_pkg::cmd_t  cmd;
	uha_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_edge    <= uha_pkg::LOW_EDGE_RST;
			cfg_q.bin_width   <= uha_pkg::BIN_WIDTH_RST;
			cfg_q.bins_in_use <= uha_pkg::BINS_IN_USE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				uha_pkg::CFG_LOW_EDGE: begin
					cfg_q.low_edge <= cfg_data;
				end
				uha_pkg::CFG_BIN_WIDTH: begin
					cfg_q.bin_width <= cfg_data;
				end
				uha_pkg::CFG_BINS_IN_USE: begin
					cfg_q.bins_in_use <= cfg_data[uha_pkg::BIU_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	uha_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	uha_datapath #(
		.MAX_BINS (MAX_BINS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg_q),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

endmodule

// ===== rtl/uha_ctrl.sv =====
// Controller state machine sequencing one histogram item at a time.
module uha_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  uha_pkg::stat_t  stat,
	output uha_pkg::cmd_t   cmd,
	output logic            busy,
	output logic            done
);

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_CHECK = 9'b000000100,
		ST_DIVB  = 9'b000001000,
		ST_CLAMP = 9'b000010000,
		ST_FETCH = 9'b000100000,
		ST_EVAL  = 9'b001000000,
		ST_DIVR  = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.is_read) begin
					cmd.rd_issue = 1'b1;
					state_d      = ST_FETCH;
				end else if (stat.below) begin
					state_d = ST_DONE;
				end else begin
					cmd.divb_start = 1'b1;
					state_d        = ST_DIVB;
				end
			end
			ST_DIVB: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_CLAMP;
				end
			end
			ST_CLAMP: begin
				cmd.clamp_rd = 1'b1;
				state_d      = ST_FETCH;
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if (stat.total_zero || stat.cnt_ge_total) begin
					state_d = ST_DONE;
				end else begin
					cmd.divr_start = 1'b1;
					state_d        = ST_DIVR;
				end
			end
			ST_DIVR: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					cmd.take_prob = 1'b1;
					state_d       = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

// ===== rtl/uha_datapath.sv =====
// Datapath: count memory, shared serial divider, counters and result registers.
module uha_datapath #(
	parameter int MAX_BINS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  uha_pkg::item_t    item,
	input  uha_pkg::cfg_t     cfg,
	input  uha_pkg::cmd_t     cmd,
	output uha_pkg::stat_t    stat,
	output uha_pkg::result_t  result
);

	localparam int AW = $clog2(MAX_BINS);
	localparam int CB = uha_pkg::COUNT_BITS;
	localparam int DB = uha_pkg::DIV_BITS;
	localparam int SB = uha_pkg::SAMPLE_BITS;

	logic [CB-1:0] mem [MAX_BINS];
	logic [CB-1:0] rd_q;

	uha_pkg::item_t item_q;
	logic                          acc_q;
	logic [uha_pkg::BIN_BITS-1:0]  bin_q;
	logic [CB-1:0]                 cnt_q;
	logic [CB-1:0]                 total_q;
	logic [uha_pkg::PROB_BITS-1:0] prob_q;
	logic                          empty_q;
	logic [AW-1:0]                 addr_q;
	logic [AW-1:0]                 clr_q;

	logic [CB-1:0]                  rem_q;
	logic [DB-1:0]                  quo_q;
	logic [CB-1:0]                  den_q;
	logic [uha_pkg::STEP_BITS-1:0]  step_q;

	logic [CB:0]   sh;
	logic          ge;
	logic [CB:0]   sub;
	logic [CB-1:0] rem_n;
	logic [DB-1:0] quo_n;

	logic              below_in;
	logic signed [SB:0] diff;
	logic [DB-1:0]     n16;
	logic [DB-1:0]     idx16;
	logic [DB-1:0]     rd16;
	logic              in_range;
	logic [CB-1:0]     inc;
	logic [CB-1:0]     total_inc;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [CB-1:0]     mem_wd;
	logic              mem_re;
	logic [AW-1:0]     mem_ra;

	// divider step: shift one bit in, subtract when it fits
	assign sh    = {rem_q, quo_q[DB-1]};
	assign ge    = (sh >= {1'b0, den_q});
	assign sub   = sh - {1'b0, den_q};
	assign rem_n = ge ? sub[CB-1:0] : sh[CB-1:0];
	assign quo_n = {quo_q[DB-2:0], ge};

	assign below_in = (item.sample < cfg.low_edge);
	assign diff     = {item_q.sample[SB-1], item_q.sample} - {cfg.low_edge[SB-1], cfg.low_edge};

	always_comb begin
		if (cfg.bins_in_use == '0) begin
			n16 = DB'(1);
		end else if (DB'(cfg.bins_in_use) > DB'(MAX_BINS)) begin
			n16 = DB'(MAX_BINS);
		end else begin
			n16 = DB'(cfg.bins_in_use);
		end
		idx16 = (quo_q >= n16) ? (n16 - DB'(1)) : quo_q;
	end

	assign rd16     = DB'(item_q.bin_index);
	assign in_range = (rd16 < DB'(MAX_BINS));

	assign inc       = (rd_q == '1) ? rd_q : rd_q + CB'(1);
	assign total_inc = (total_q == '1) ? total_q : total_q + CB'(1);

	assign mem_we = cmd.clr_step | (cmd.fetch & (item_q.func == uha_pkg::FUNC_ADD));
	assign mem_wa = cmd.clr_step ? clr_q : addr_q;
	assign mem_wd = cmd.clr_step ? '0 : inc;
	assign mem_re = cmd.rd_issue | cmd.clamp_rd;
	assign mem_ra = cmd.rd_issue ? rd16[AW-1:0] : idx16[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			total_q <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.fetch && item_q.func == uha_pkg::FUNC_ADD) begin
				total_q <= total_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q  <= item;
			acc_q   <= (item.func == uha_pkg::FUNC_READ) | ~below_in;
			bin_q   <= (item.func == uha_pkg::FUNC_READ) ? item.bin_index : '0;
			cnt_q   <= '0;
			prob_q  <= '0;
			empty_q <= 1'b0;
		end
		if (cmd.rd_issue) begin
			addr_q <= rd16[AW-1:0];
		end
		if (cmd.clamp_rd) begin
			addr_q <= idx16[AW-1:0];
			bin_q  <= idx16[uha_pkg::BIN_BITS-1:0];
		end
		if (cmd.fetch) begin
			if (item_q.func == uha_pkg::FUNC_READ) begin
				cnt_q <= in_range ? rd_q : '0;
			end else begin
				cnt_q <= inc;
			end
		end
		if (cmd.eval) begin
			if (total_q == '0) begin
				empty_q <= 1'b1;
			end else if (cnt_q >= total_q) begin
				prob_q <= uha_pkg::PROB_ONE;
			end
		end
		if (cmd.divb_start) begin
			rem_q  <= '0;
			quo_q  <= diff[DB-1:0];
			den_q  <= (cfg.bin_width == '0) ? CB'(1) : CB'(cfg.bin_width);
			step_q <= '0;
		end
		if (cmd.divr_start) begin
			rem_q  <= cnt_q;
			quo_q  <= '0;
			den_q  <= total_q;
			step_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= rem_n;
			quo_q  <= quo_n;
			step_q <= step_q + uha_pkg::STEP_BITS'(1);
		end
		if (cmd.take_prob) begin
			prob_q <= {1'b0, quo_n};
		end
	end

	assign stat.clr_last     = (clr_q == AW'(MAX_BINS - 1));
	assign stat.is_read      = (item_q.func == uha_pkg::FUNC_READ);
	assign stat.below        = ~acc_q;
	assign stat.div_last     = (step_q == uha_pkg::STEP_BITS'(DB - 1));
	assign stat.total_zero   = (total_q == '0);
	assign stat.cnt_ge_total = (cnt_q >= total_q);

	assign result.accepted    = acc_q;
	assign result.bin         = bin_q;
	assign result.bin_count   = cnt_q;
	assign result.total_count = total_q;
	assign result.probability = prob_q;
	assign result.empty_res   = empty_q;

endmodule
